// ===== sv/jse_pkg.sv =====
`timescale 1ns / 1ps

package jse_pkg;

    localparam logic [7:0] QUOTE_CHAR     = 8'h22;
    localparam logic [7:0] BACKSLASH_CHAR = 8'h5C;
    localparam logic [7:0] U_CHAR         = 8'h75;
    localparam logic [7:0] ZERO_CHAR      = 8'h30;
    localparam logic [7:0] REP_BYTE0      = 8'hEF;
    localparam logic [7:0] REP_BYTE1      = 8'hBF;
    localparam logic [7:0] REP_BYTE2      = 8'hBD;
    localparam logic [20:0] MAX_CODEPOINT = 21'h10FFFF;
    localparam logic [20:0] SURR_LOW      = 21'h00D800;
    localparam logic [20:0] SURR_HIGH     = 21'h00DFFF;
    localparam logic [20:0] MIN_LEN2      = 21'h000080;
    localparam logic [20:0] MIN_LEN3      = 21'h000800;
    localparam logic [20:0] MIN_LEN4      = 21'h010000;
    localparam int BODY_DEPTH = 6;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       starts_string;
        logic       ends_string;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       run_last;
        logic       string_closed;
    } out_item_t;

    // byte positions of one transfer's output runs
    typedef struct packed {
        logic                           open_quote;
        logic                           close_quote;
        logic [4:0]                     pre_end;
        logic [4:0]                     body_end;
        logic [4:0]                     post_end;
        logic [4:0]                     total;
        logic [BODY_DEPTH-1:0][7:0]     body;
    } jse_desc_t;

    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        logic [7:0] c;
        if (nib < 4'd10) begin
            c = 8'h30 + {4'b0, nib};
        end else begin
            c = 8'h57 + {4'b0, nib};
        end
        return c;
    endfunction

    // two-byte escape letter, zero when none
    function automatic logic [7:0] esc_char(input logic [7:0] b);
        logic [7:0] e;
        unique case (b)
            8'h22:   e = 8'h22;
            8'h5C:   e = 8'h5C;
            8'h0A:   e = 8'h6E;
            8'h0D:   e = 8'h72;
            8'h09:   e = 8'h74;
            8'h08:   e = 8'h62;
            8'h0C:   e = 8'h66;
            default: e = 8'h00;
        endcase
        return e;
    endfunction

    function automatic logic [1:0] mod3(input logic [3:0] v);
        logic [1:0] r;
        unique case (v)
            4'd0, 4'd3, 4'd6, 4'd9, 4'd12, 4'd15: r = 2'd0;
            4'd1, 4'd4, 4'd7, 4'd10, 4'd13:       r = 2'd1;
            default:                              r = 2'd2;
        endcase
        return r;
    endfunction

    function automatic logic [7:0] rep_byte(input logic [1:0] phase);
        logic [7:0] r;
        unique case (phase)
            2'd0:    r = REP_BYTE0;
            2'd1:    r = REP_BYTE1;
            default: r = REP_BYTE2;
        endcase
        return r;
    endfunction

endpackage

// ===== sv/jse_decoder.sv =====
`timescale 1ns / 1ps

module jse_decoder (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               accept,
    input  jse_pkg::in_item_t  item,
    output jse_pkg::jse_desc_t desc
);
    import jse_pkg::*;

    logic [2:0][7:0] held_reg, held_next;
    logic [1:0]      count_reg, count_next;
    logic [2:0]      seq_len_reg, seq_len_next;
    logic [20:0]     cp_reg, cp_next;

    logic [7:0]  b;
    logic [1:0]  base_count;
    logic [20:0] new_cp;
    logic        run_fresh;
    logic        bad;
    logic [7:0]  esc;
    logic [2:0]  pre_cnt;
    logic [1:0]  post_cnt;
    logic [2:0]  body_len;
    logic [1:0]  store_idx;
    logic [4:0]  pre3;
    logic [4:0]  post3;

    always_comb begin
        b          = item.data_byte;
        base_count = item.starts_string ? 2'd0 : count_reg;
        new_cp     = {cp_reg[14:0], b[5:0]};
        held_next  = held_reg;
        count_next = base_count;
        seq_len_next = seq_len_reg;
        cp_next    = cp_reg;
        run_fresh  = 1'b0;
        pre_cnt    = 3'd0;
        body_len   = 3'd0;
        desc.body  = '0;
        esc        = esc_char(b);
        store_idx  = (base_count == 2'd3) ? 2'd0 : base_count;
        bad = ((seq_len_reg == 3'd2) && (new_cp < MIN_LEN2)) ||
              ((seq_len_reg == 3'd3) && (new_cp < MIN_LEN3)) ||
              ((seq_len_reg == 3'd4) && (new_cp < MIN_LEN4)) ||
              (new_cp > MAX_CODEPOINT) ||
              ((new_cp >= SURR_LOW) && (new_cp <= SURR_HIGH));

        if (base_count == 2'd0) begin
            run_fresh = 1'b1;
        end else if (b[7:6] != 2'b10) begin
            // broken sequence
            pre_cnt    = {1'b0, base_count};
            count_next = 2'd0;
            run_fresh  = 1'b1;
        end else begin
            cp_next = new_cp;
            if (({1'b0, base_count} + 3'd1) >= seq_len_reg) begin
                count_next = 2'd0;
                if (bad) begin
                    pre_cnt = seq_len_reg;
                end else begin
                    desc.body[0] = held_reg[0];
                    desc.body[1] = held_reg[1];
                    desc.body[2] = held_reg[2];
                    desc.body[base_count] = b;
                    body_len = {1'b0, base_count} + 3'd1;
                end
            end else begin
                held_next[store_idx] = b;
                count_next = base_count + 2'd1;
            end
        end

        if (run_fresh) begin
            if (!b[7]) begin
                if (esc != 8'h00) begin
                    desc.body[0] = BACKSLASH_CHAR;
                    desc.body[1] = esc;
                    body_len = 3'd2;
                end else if (b < 8'h20) begin
                    desc.body[0] = BACKSLASH_CHAR;
                    desc.body[1] = U_CHAR;
                    desc.body[2] = ZERO_CHAR;
                    desc.body[3] = ZERO_CHAR;
                    desc.body[4] = hex_char(b[7:4]);
                    desc.body[5] = hex_char(b[3:0]);
                    body_len = 3'd6;
                end else begin
                    desc.body[0] = b;
                    body_len = 3'd1;
                end
            end else if (b[7:5] == 3'b110) begin
                held_next[0] = b;
                count_next   = 2'd1;
                seq_len_next = 3'd2;
                cp_next      = {16'b0, b[4:0]};
            end else if (b[7:4] == 4'b1110) begin
                held_next[0] = b;
                count_next   = 2'd1;
                seq_len_next = 3'd3;
                cp_next      = {17'b0, b[3:0]};
            end else if (b[7:3] == 5'b11110) begin
                held_next[0] = b;
                count_next   = 2'd1;
                seq_len_next = 3'd4;
                cp_next      = {18'b0, b[2:0]};
            end else begin
                pre_cnt = pre_cnt + 3'd1;
            end
        end

        post_cnt = item.ends_string ? count_next : 2'd0;
        if (item.ends_string) begin
            count_next = 2'd0;
        end

        pre3  = ({2'b0, pre_cnt} << 1) + {2'b0, pre_cnt};
        post3 = ({3'b0, post_cnt} << 1) + {3'b0, post_cnt};
        desc.open_quote  = item.starts_string;
        desc.close_quote = item.ends_string;
        desc.pre_end     = {4'b0, item.starts_string} + pre3;
        desc.body_end    = desc.pre_end + {2'b0, body_len};
        desc.post_end    = desc.body_end + post3;
        desc.total       = desc.post_end + {4'b0, item.ends_string};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            held_reg    <= '0;
            count_reg   <= '0;
            seq_len_reg <= '0;
            cp_reg      <= '0;
        end else if (accept) begin
            held_reg    <= held_next;
            count_reg   <= count_next;
            seq_len_reg <= seq_len_next;
            cp_reg      <= cp_next;
        end
    end

endmodule

// ===== sv/jse_emitter.sv =====
`timescale 1ns / 1ps

module jse_emitter (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                load,
    input  jse_pkg::jse_desc_t  desc_in,
    output logic                take_ready,
    output logic                m_valid,
    input  logic                m_ready,
    output jse_pkg::out_item_t  m_data
);
    import jse_pkg::*;

    jse_desc_t  job_reg;
    logic       job_valid_reg, job_valid_next;
    logic [3:0] idx_reg, idx_next;
    logic       m_valid_reg, m_valid_next;
    out_item_t  m_data_reg, m_data_next;

    logic       emit_ok;
    logic       job_last;
    logic [4:0] idx5;
    logic [4:0] off_pre;
    logic [4:0] off_body;
    logic [4:0] off_post;
    logic [7:0] byte_sel;

    always_comb begin
        idx5     = {1'b0, idx_reg};
        off_pre  = idx5 - {4'b0, job_reg.open_quote};
        off_body = idx5 - job_reg.pre_end;
        off_post = idx5 - job_reg.body_end;
        emit_ok  = job_valid_reg && (!m_valid_reg || m_ready);
        job_last = (idx5 == (job_reg.total - 5'd1));
        take_ready = !job_valid_reg || (emit_ok && job_last);

        if (idx5 < {4'b0, job_reg.open_quote}) begin
            byte_sel = QUOTE_CHAR;
        end else if (idx5 < job_reg.pre_end) begin
            byte_sel = rep_byte(mod3(off_pre[3:0]));
        end else if (idx5 < job_reg.body_end) begin
            byte_sel = job_reg.body[off_body[2:0]];
        end else if (idx5 < job_reg.post_end) begin
            byte_sel = rep_byte(mod3(off_post[3:0]));
        end else begin
            byte_sel = QUOTE_CHAR;
        end

        m_data_next.out_byte      = byte_sel;
        m_data_next.run_last      = job_last;
        m_data_next.string_closed = job_reg.close_quote && (idx5 == job_reg.post_end);

        job_valid_next = job_valid_reg;
        idx_next       = idx_reg;
        if (load) begin
            job_valid_next = 1'b1;
            idx_next       = 4'd0;
        end else if (emit_ok) begin
            job_valid_next = !job_last;
            idx_next       = idx_reg + 4'd1;
        end

        m_valid_next = m_valid_reg;
        if (emit_ok) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            job_valid_reg <= 1'b0;
            idx_reg       <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            job_valid_reg <= job_valid_next;
            idx_reg       <= idx_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            job_reg <= desc_in;
        end
        if (emit_ok) begin
            m_data_reg <= m_data_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

// ===== sv/json_string_escaper_top.sv =====
`timescale 1ns / 1ps
// channel   direction  handshake          payload
// s_        in         s_valid / s_ready  in_item_t: data_byte, starts_string, ends_string
// m_        out        m_valid / m_ready  out_item_t: out_byte, run_last, string_closed
//
// one transfer is accepted per cycle when it yields at most one output byte
// a transfer yielding n bytes (up to 16) holds the input while the
// job register drains into the output register, one byte per cycle while m_ready does not stall
// a transfer that only holds a utf-8 lead byte yields nothing and is not loaded into the job register
// aresetn is synchronous; it clears the held sequence and empties both registers
// a stall on m_ready holds the output byte and, once the job is done, the input

module json_string_escaper_top (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  jse_pkg::in_item_t  s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output jse_pkg::out_item_t m_data
);
    import jse_pkg::*;

    jse_desc_t desc;
    logic      take_ready;
    logic      s_fire;
    logic      load;

    assign s_ready = take_ready;
    assign s_fire  = s_valid && take_ready;
    assign load    = s_fire && (desc.total != 5'd0);

    jse_decoder u_decoder (
        .aclk    (aclk),
        .aresetn (aresetn),
        .accept  (s_fire),
        .item    (s_data),
        .desc    (desc)
    );

    jse_emitter u_emitter (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .load       (load),
        .desc_in    (desc),
        .take_ready (take_ready),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data)
    );

`ifndef SYNTHESIS
    a_close_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.string_closed |-> m_data.run_last)
        else $error("closing quote not last byte of its transfer");

    a_close_is_quote: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.string_closed |-> (m_data.out_byte == QUOTE_CHAR))
        else $error("closing mark on a byte other than a quote");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid && s_ready)
        else $error("registers not empty after reset");

    a_out_stable: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("output transfer changed while stalled");
`endif

endmodule
